>>> design/spmm_pkg.sv
`timescale 1ns / 1ps
package spmm_pkg;

  localparam int COORD_BITS = 9;
  localparam int ADDR_BITS  = 2 * COORD_BITS;
  localparam int PIX_BITS   = 8;

  localparam logic [ADDR_BITS-1:0] ADDR_LAST = {ADDR_BITS{1'b1}};

  // screen position constants, mode 0
  localparam logic [7:0]            M0_X_BIAS = 8'd4;
  localparam logic [7:0]            M0_Y_BASE = 8'd240;
  localparam logic [COORD_BITS-1:0] M0_FLIP_X = 9'd466;
  localparam logic [COORD_BITS-1:0] M0_FLIP_Y = 9'd450;
  // screen position constants, mode 1
  localparam logic [7:0]            M1_X_BIAS = 8'd3;
  localparam logic [7:0]            M1_Y_BASE = 8'd241;
  localparam logic [COORD_BITS-1:0] M1_FLIP_X = 9'd480;
  localparam logic [COORD_BITS-1:0] M1_FLIP_Y = 9'd452;
  localparam logic [COORD_BITS-1:0] M1_FIRST_ROW = 9'd2;

  localparam logic [PIX_BITS-1:0] PRI_MARK  = 8'hff;
  localparam logic [PIX_BITS-1:0] PRI_CLEAR = 8'h00;
  localparam logic [PIX_BITS-1:0] DRAW_MASK = 8'h07;
  localparam logic [PIX_BITS-1:0] MARK_MASK = 8'h0f;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 9;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RENDER_MODE   = 3'd0,
    CFG_COCKTAIL_FLIP = 3'd1,
    CFG_X_OFF_NORMAL  = 3'd2,
    CFG_X_OFF_FLIPPED = 3'd3,
    CFG_COLOR_MASK    = 3'd4,
    CFG_COLOR_BASE    = 3'd5,
    CFG_CLIP_TOP      = 3'd6,
    CFG_CLIP_BOTTOM   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                  render_mode;
    logic                  cocktail_flip;
    logic [7:0]            x_offset_normal;
    logic [7:0]            x_offset_flipped;
    logic [7:0]            sprite_color_mask;
    logic [7:0]            color_base;
    logic [COORD_BITS-1:0] clip_top;
    logic [COORD_BITS-1:0] clip_bottom;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_OR_MERGE,
    OP_FIRST_WINS
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  data;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } back_state_t;

endpackage

>>> design/sprite_pixel_priority_merge_core.sv
`timescale 1ns / 1ps
// channel  | signals                                   | accepted when
// ---------+-------------------------------------------+----------------------
// input    | in_valid/in_ready, req_type .. pri_value  | in_valid & in_ready
// output   | out_valid/out_ready, screen_x/y, pixel    | out_valid & out_ready
// config   | cfg_write, cfg_index, cfg_data            | cfg_write
//
// A priority write goes into the store as it leaves the queue; a sprite pixel
// is read into a register, then modified and written back on the single store port.
// Clipped pixels are dropped at the front in the cycle they are taken.
// After reset the store is cleared one entry a cycle, all 262144 entries, and
// in_ready stays low until that pass ends. The queue lets the front keep
// taking items while the back waits on out_ready.
module sprite_pixel_priority_merge_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [7:0]                          sprite_y,
  input  logic [7:0]                          sprite_attr,
  input  logic [7:0]                          sprite_x,
  input  logic [4:0]                          pattern_row,
  input  logic [4:0]                          pattern_col,
  input  logic [7:0]                          pattern_pixel,
  input  logic [spmm_pkg::COORD_BITS-1:0]     pri_x,
  input  logic [spmm_pkg::COORD_BITS-1:0]     pri_y,
  input  logic [7:0]                          pri_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spmm_pkg::COORD_BITS-1:0]     screen_x,
  output logic [spmm_pkg::COORD_BITS-1:0]     screen_y,
  output logic [7:0]                          pixel_value,
  input  logic                                cfg_write,
  input  logic [spmm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [spmm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import spmm_pkg::*;

  cfg_t   cfg;
  logic   clearing;
  logic   q_ready;
  logic   q_valid;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.render_mode       <= 1'b0;
      cfg.cocktail_flip     <= 1'b0;
      cfg.x_offset_normal   <= 8'd0;
      cfg.x_offset_flipped  <= 8'd0;
      cfg.sprite_color_mask <= 8'd48;
      cfg.color_base        <= 8'd0;
      cfg.clip_top          <= 9'd0;
      cfg.clip_bottom       <= 9'd511;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RENDER_MODE:   cfg.render_mode       <= cfg_data[0];
        CFG_COCKTAIL_FLIP: cfg.cocktail_flip     <= cfg_data[0];
        CFG_X_OFF_NORMAL:  cfg.x_offset_normal   <= cfg_data[7:0];
        CFG_X_OFF_FLIPPED: cfg.x_offset_flipped  <= cfg_data[7:0];
        CFG_COLOR_MASK:    cfg.sprite_color_mask <= cfg_data[7:0];
        CFG_COLOR_BASE:    cfg.color_base        <= cfg_data[7:0];
        CFG_CLIP_TOP:      cfg.clip_top          <= cfg_data[COORD_BITS-1:0];
        CFG_CLIP_BOTTOM:   cfg.clip_bottom       <= cfg_data[COORD_BITS-1:0];
        default:           cfg.render_mode       <= cfg.render_mode;
      endcase
    end
  end

  spmm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .sprite_y      (sprite_y),
    .sprite_attr   (sprite_attr),
    .sprite_x      (sprite_x),
    .pattern_row   (pattern_row),
    .pattern_col   (pattern_col),
    .pattern_pixel (pattern_pixel),
    .pri_x         (pri_x),
    .pri_y         (pri_y),
    .pri_value     (pri_value),
    .cfg           (cfg),
    .clearing      (clearing),
    .q_ready       (q_ready),
    .push          (push),
    .push_entry    (push_entry)
  );

  spmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  spmm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .pixel_value (pixel_value)
  );

endmodule

>>> design/spmm_queue.sv
`timescale 1ns / 1ps
module spmm_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spmm_pkg::entry_t push_entry,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output spmm_pkg::entry_t q_entry
);
  import spmm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push_ok;
  logic            pop_ok;

  assign q_valid = (count != '0);
  assign q_ready = (count != CNT_FULL);
  assign push_ok = push && q_ready;
  assign pop_ok  = pop && q_valid;
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/spmm_front.sv
`timescale 1ns / 1ps
module spmm_front (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [7:0]                        sprite_y,
  input  logic [7:0]                        sprite_attr,
  input  logic [7:0]                        sprite_x,
  input  logic [4:0]                        pattern_row,
  input  logic [4:0]                        pattern_col,
  input  logic [7:0]                        pattern_pixel,
  input  logic [spmm_pkg::COORD_BITS-1:0]   pri_x,
  input  logic [spmm_pkg::COORD_BITS-1:0]   pri_y,
  input  logic [7:0]                        pri_value,
  input  spmm_pkg::cfg_t                    cfg,
  input  logic                              clearing,
  input  logic                              q_ready,
  output logic                              push,
  output spmm_pkg::entry_t                  push_entry
);
  import spmm_pkg::*;

  logic [COORD_BITS-1:0] base_x;
  logic [COORD_BITS-1:0] base_y;
  logic [COORD_BITS-1:0] sx;
  logic [COORD_BITS-1:0] sy;
  logic [COORD_BITS-1:0] tx;
  logic [COORD_BITS-1:0] ty;
  logic [COORD_BITS-1:0] off_n;
  logic [COORD_BITS-1:0] off_f;
  logic                  hflip;
  logic                  vflip;
  logic [4:0]            col_f;
  logic [4:0]            row_f;
  logic                  clipped;
  logic [PIX_BITS-1:0]   color;

  assign off_n = {cfg.x_offset_normal[7], cfg.x_offset_normal};
  assign off_f = {cfg.x_offset_flipped[7], cfg.x_offset_flipped};

  always_comb begin
    if (cfg.render_mode) begin
      base_x = {sprite_x - M1_X_BIAS, 1'b0};
      base_y = {M1_Y_BASE - sprite_y, 1'b0};
      hflip  = sprite_attr[4] ^ cfg.cocktail_flip;
      vflip  = sprite_attr[5] ^ cfg.cocktail_flip;
      sx     = cfg.cocktail_flip ? M1_FLIP_X - base_x : base_x;
      sy     = cfg.cocktail_flip ? M1_FLIP_Y - base_y : base_y;
    end else begin
      base_x = {sprite_x - M0_X_BIAS, 1'b0};
      base_y = {M0_Y_BASE - sprite_y, 1'b0};
      hflip  = sprite_attr[6] ^ cfg.cocktail_flip;
      vflip  = sprite_attr[7] ^ cfg.cocktail_flip;
      sx     = cfg.cocktail_flip ? M0_FLIP_X - base_x + off_f : base_x + off_n;
      sy     = cfg.cocktail_flip ? M0_FLIP_Y - base_y : base_y;
    end
  end

  assign col_f = pattern_col ^ {5{hflip}};
  assign row_f = pattern_row ^ {5{vflip}};
  assign tx    = sx + {{(COORD_BITS-5){1'b0}}, col_f};
  assign ty    = sy + {{(COORD_BITS-5){1'b0}}, row_f};

  assign clipped = (ty < cfg.clip_top) || (ty > cfg.clip_bottom) ||
                   (cfg.render_mode && (ty < M1_FIRST_ROW));

  assign color = ({2'b00, ~sprite_attr[1:0], 4'b0000} & cfg.sprite_color_mask) |
                 cfg.color_base;

  always_comb begin
    if (!req_type) begin
      push_entry.op   = OP_WRITE;
      push_entry.addr = {pri_y, pri_x};
      push_entry.data = pri_value;
    end else if (cfg.render_mode) begin
      push_entry.op   = OP_FIRST_WINS;
      push_entry.addr = {ty, tx};
      push_entry.data = color | pattern_pixel;
    end else begin
      push_entry.op   = OP_OR_MERGE;
      push_entry.addr = {ty, tx};
      push_entry.data = pattern_pixel;
    end
  end

  assign in_ready = !clearing && q_ready;
  // clipped pixels are taken and dropped here
  assign push     = in_valid && in_ready && (!req_type || !clipped);

endmodule

>>> design/spmm_back.sv
`timescale 1ns / 1ps
module spmm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  spmm_pkg::entry_t                q_entry,
  output logic                            pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spmm_pkg::COORD_BITS-1:0] screen_x,
  output logic [spmm_pkg::COORD_BITS-1:0] screen_y,
  output logic [7:0]                      pixel_value
);
  import spmm_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [PIX_BITS-1:0]  store [DEPTH];
  logic [PIX_BITS-1:0]  rdata;

  back_state_t          state;
  back_state_t          state_next;
  logic [ADDR_BITS-1:0] clear_addr;
  entry_t               cur;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [PIX_BITS-1:0]  mem_wdata;
  logic                 mem_re;
  logic                 load_out;

  logic [PIX_BITS-1:0]  merged;
  logic [PIX_BITS-1:0]  result_pix;
  logic                 result_wr;
  logic [PIX_BITS-1:0]  result_wdata;
  logic                 drawn;
  logic                 stall;

  always_comb begin
    merged = rdata | cur.data;
    if (cur.op == OP_FIRST_WINS) begin
      result_pix   = cur.data;
      result_wdata = PRI_MARK;
      result_wr    = (cur.data & MARK_MASK) != '0;
      drawn        = (rdata != PRI_MARK) && ((cur.data & DRAW_MASK) != '0);
    end else begin
      result_pix   = merged;
      result_wdata = merged;
      result_wr    = 1'b1;
      drawn        = (merged & DRAW_MASK) != '0;
    end
  end

  assign stall    = drawn && out_valid && !out_ready;
  assign clearing = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid && (q_entry.op != OP_WRITE)) state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (!stall) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = q_entry.addr;
    mem_wdata = q_entry.data;
    mem_re    = 1'b0;
    pop       = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = PRI_CLEAR;
      end
      ST_IDLE: begin
        pop    = q_valid;
        mem_we = q_valid && (q_entry.op == OP_WRITE);
        mem_re = q_valid && (q_entry.op != OP_WRITE);
      end
      ST_MODIFY: begin
        mem_we    = result_wr && !stall;
        mem_waddr = cur.addr;
        mem_wdata = result_wdata;
        load_out  = drawn && !stall;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= store[q_entry.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
    if (load_out) begin
      screen_x    <= cur.addr[COORD_BITS-1:0];
      screen_y    <= cur.addr[ADDR_BITS-1:COORD_BITS];
      pixel_value <= result_pix;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import spmm_pkg::*;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PIX_BITS-1:0]   value;
  } frame_pixel_t;

  class pixel_merge_model;
    cfg_t                  cfg;
    logic [PIX_BITS-1:0]   pri_store [1 << ADDR_BITS];
    frame_pixel_t          drawn_q[$];
    int                    errors;
    logic [COORD_BITS-1:0] aim_x;
    logic [COORD_BITS-1:0] aim_y;

    function new();
      foreach (pri_store[i]) pri_store[i] = PRI_CLEAR;
      cfg = '0;
      cfg.sprite_color_mask = 8'd48;
      cfg.clip_bottom = '1;
      errors = 0;
      aim_x = '0;
      aim_y = '0;
    endfunction

    function int pending();
      return drawn_q.size();
    endfunction

    // screen position of one pattern pixel under the current settings
    function void locate(input logic [7:0] ys, input logic [7:0] attr, input logic [7:0] xs,
                         input logic [4:0] row, input logic [4:0] col,
                         output logic [COORD_BITS-1:0] tx, output logic [COORD_BITS-1:0] ty);
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
      logic [4:0]            hf;
      logic [4:0]            vf;
      if (!cfg.render_mode) begin
        hf = attr[6] ? 5'd31 : 5'd0;
        vf = attr[7] ? 5'd31 : 5'd0;
        sx = {8'(xs - M0_X_BIAS), 1'b0};
        sy = {8'(M0_Y_BASE - ys), 1'b0};
        if (cfg.cocktail_flip) begin
          hf = ~hf;
          vf = ~vf;
          sx = M0_FLIP_X - sx + {cfg.x_offset_flipped[7], cfg.x_offset_flipped};
          sy = M0_FLIP_Y - sy;
        end else begin
          sx = sx + {cfg.x_offset_normal[7], cfg.x_offset_normal};
        end
      end else begin
        hf = attr[4] ? 5'd31 : 5'd0;
        vf = attr[5] ? 5'd31 : 5'd0;
        sx = {8'(xs - M1_X_BIAS), 1'b0};
        sy = {8'(M1_Y_BASE - ys), 1'b0};
        if (cfg.cocktail_flip) begin
          hf = ~hf;
          vf = ~vf;
          sx = M1_FLIP_X - sx;
          sy = M1_FLIP_Y - sy;
        end
      end
      ty = sy + {4'b0000, row ^ vf};
      tx = sx + {4'b0000, col ^ hf};
      aim_x = tx;
      aim_y = ty;
    endfunction

    function void take_request(input logic req, input logic [7:0] ys, input logic [7:0] attr,
                               input logic [7:0] xs, input logic [4:0] row,
                               input logic [4:0] col, input logic [7:0] ppix,
                               input logic [COORD_BITS-1:0] px,
                               input logic [COORD_BITS-1:0] py, input logic [7:0] pval);
      logic [COORD_BITS-1:0] tx;
      logic [COORD_BITS-1:0] ty;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIX_BITS-1:0]   pix;
      logic [PIX_BITS-1:0]   color;
      logic                  drawn;
      if (req == REQ_WRITE) begin
        pri_store[{py, px}] = pval;
        return;
      end
      locate(ys, attr, xs, row, col, tx, ty);
      if (ty < cfg.clip_top || ty > cfg.clip_bottom) return;
      if (cfg.render_mode && ty < M1_FIRST_ROW) return;
      addr = {ty, tx};
      drawn = 1'b0;
      pix = PRI_CLEAR;
      if (!cfg.render_mode) begin
        pix = pri_store[addr] | ppix;
        pri_store[addr] = pix;
        drawn = |(pix & DRAW_MASK);
      end else if (pri_store[addr] != PRI_MARK) begin
        color = ({2'b00, ~attr[1:0], 4'b0000} & cfg.sprite_color_mask) | cfg.color_base;
        pix = color | ppix;
        if (|(pix & MARK_MASK)) begin
          pri_store[addr] = PRI_MARK;
          drawn = |(pix & DRAW_MASK);
        end
      end
      if (drawn) drawn_q.push_back('{tx, ty, pix});
    endfunction

    function void check_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [PIX_BITS-1:0] v);
      frame_pixel_t want;
      if (drawn_q.size() == 0) begin
        $error("pixel (%0d,%0d) value %0d with none expected", x, y, v);
        errors++;
        return;
      end
      want = drawn_q.pop_front();
      if (x !== want.x) begin
        $error("screen_x: expected %0d, actual %0d", want.x, x);
        errors++;
      end
      if (y !== want.y) begin
        $error("screen_y: expected %0d, actual %0d", want.y, y);
        errors++;
      end
      if (v !== want.value) begin
        $error("pixel_value: expected %0d, actual %0d", want.value, v);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic [7:0]                sprite_y;
  logic [7:0]                sprite_attr;
  logic [7:0]                sprite_x;
  logic [4:0]                pattern_row;
  logic [4:0]                pattern_col;
  logic [7:0]                pattern_pixel;
  logic [COORD_BITS-1:0]     pri_x;
  logic [COORD_BITS-1:0]     pri_y;
  logic [7:0]                pri_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [COORD_BITS-1:0]     screen_x;
  logic [COORD_BITS-1:0]     screen_y;
  logic [7:0]                pixel_value;
  logic                      cfg_write;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  pixel_merge_model sb = new();
  logic             quiet;
  logic             hold_off;
  logic [7:0]       pool_y [4];
  logic [7:0]       pool_x [4];

  sprite_pixel_priority_merge_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sprite_y     (sprite_y),
    .sprite_attr  (sprite_attr),
    .sprite_x     (sprite_x),
    .pattern_row  (pattern_row),
    .pattern_col  (pattern_col),
    .pattern_pixel(pattern_pixel),
    .pri_x        (pri_x),
    .pri_y        (pri_y),
    .pri_value    (pri_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .pixel_value  (pixel_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random back-pressure plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready = quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pixel(screen_x, screen_y, pixel_value);
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic req, input logic [7:0] ys, input logic [7:0] attr,
                           input logic [7:0] xs, input logic [4:0] row, input logic [4:0] col,
                           input logic [7:0] ppix, input logic [COORD_BITS-1:0] px,
                           input logic [COORD_BITS-1:0] py, input logic [7:0] pval);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_type = req;
    sprite_y = ys;
    sprite_attr = attr;
    sprite_x = xs;
    pattern_row = row;
    pattern_col = col;
    pattern_pixel = ppix;
    pri_x = px;
    pri_y = py;
    pri_value = pval;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_request(req, ys, attr, xs, row, col, ppix, px, py, pval);
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] ys, input logic [7:0] attr, input logic [7:0] xs,
                            input logic [4:0] row, input logic [4:0] col,
                            input logic [7:0] ppix);
    send_item(REQ_PIXEL, ys, attr, xs, row, col, ppix, 9'($urandom), 9'($urandom),
              8'($urandom));
  endtask

  // priority write aimed at the entry a given sprite pixel lands on
  task automatic send_write_at(input logic [7:0] ys, input logic [7:0] attr,
                               input logic [7:0] xs, input logic [4:0] row,
                               input logic [4:0] col, input logic [7:0] val);
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    sb.locate(ys, attr, xs, row, col, tx, ty);
    send_item(REQ_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
              5'($urandom), 8'($urandom), tx, ty, val);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    write_reg(CFG_RENDER_MODE, 9'(c.render_mode));
    write_reg(CFG_COCKTAIL_FLIP, 9'(c.cocktail_flip));
    write_reg(CFG_X_OFF_NORMAL, 9'(c.x_offset_normal));
    write_reg(CFG_X_OFF_FLIPPED, 9'(c.x_offset_flipped));
    write_reg(CFG_COLOR_MASK, 9'(c.sprite_color_mask));
    write_reg(CFG_COLOR_BASE, 9'(c.color_base));
    write_reg(CFG_CLIP_TOP, c.clip_top);
    write_reg(CFG_CLIP_BOTTOM, c.clip_bottom);
    cfg_write = 1'b0;
    sb.cfg = c;
  endtask

  // wait out all results, then let items with no result leave the pipe
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  initial begin
    cfg_t                  c;
    cfg_t                  c_reset;
    int                    r;
    int                    k;
    int                    n_items;
    logic [7:0]            ys;
    logic [7:0]            xs;
    logic [4:0]            row;
    logic [4:0]            col;
    logic [7:0]            ppix;
    logic [7:0]            pval;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;

    rst = 1'b1;
    quiet = 1'b0;
    hold_off = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    sprite_y = '0;
    sprite_attr = '0;
    sprite_x = '0;
    pattern_row = '0;
    pattern_col = '0;
    pattern_pixel = '0;
    pri_x = '0;
    pri_y = '0;
    pri_value = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_RENDER_MODE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // store clear pass after reset
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);

    c_reset = '0;
    c_reset.sprite_color_mask = 8'd48;
    c_reset.clip_bottom = '1;

    // OR-merge, reset settings
    write_cfg(c_reset);
    send_item(REQ_WRITE, 8'h00, 8'h00, 8'h00, 5'd0, 5'd0, 8'h00, 9'd0, 9'd0, 8'h00);
    send_item(REQ_WRITE, 8'hff, 8'hff, 8'hff, 5'd31, 5'd31, 8'hff, 9'd511, 9'd511, 8'hff);
    send_pixel(8'd0, 8'h00, 8'd0, 5'd0, 5'd0, 8'h00);
    send_pixel(8'd255, 8'hc0, 8'd255, 5'd31, 5'd31, 8'hff);
    send_pixel(8'd16, 8'h40, 8'd20, 5'd5, 5'd9, 8'h08);
    send_pixel(8'd16, 8'h40, 8'd20, 5'd5, 5'd9, 8'h01);
    send_write_at(8'd100, 8'h80, 8'd50, 5'd3, 5'd7, 8'h02);
    send_pixel(8'd100, 8'h80, 8'd50, 5'd3, 5'd7, 8'h00);
    send_pixel(8'd200, 8'h3f, 8'd128, 5'd16, 5'd1, 8'h80);
    settle();

    // first-wins, cabinet flipped
    c = c_reset;
    c.render_mode = 1'b1;
    c.cocktail_flip = 1'b1;
    c.sprite_color_mask = 8'hff;
    write_cfg(c);
    send_pixel(8'd15, 8'h20, 8'd40, 5'd0, 5'd4, 8'hff);
    send_pixel(8'd15, 8'h20, 8'd40, 5'd1, 5'd4, 8'hff);
    send_pixel(8'd60, 8'h03, 8'd70, 5'd6, 5'd6, 8'h00);
    send_pixel(8'd60, 8'h03, 8'd70, 5'd6, 5'd6, 8'h08);
    send_pixel(8'd60, 8'h03, 8'd70, 5'd6, 5'd6, 8'h07);
    send_write_at(8'd90, 8'h10, 8'd30, 5'd2, 5'd8, 8'hff);
    send_pixel(8'd90, 8'h10, 8'd30, 5'd2, 5'd8, 8'h01);
    send_write_at(8'd90, 8'h10, 8'd30, 5'd2, 5'd8, 8'h00);
    send_pixel(8'd90, 8'h10, 8'd30, 5'd2, 5'd8, 8'h01);
    send_pixel(8'd120, 8'h00, 8'd10, 5'd9, 5'd12, 8'h30);
    send_pixel(8'd120, 8'h00, 8'd10, 5'd9, 5'd12, 8'h04);
    settle();

    for (int p = 0; p < 9; p++) begin
      c = c_reset;
      case (p)
        1: begin
          c.render_mode = 1'b1;
        end
        2: begin
          c.cocktail_flip = 1'b1;
          c.x_offset_normal = 8'h80;
          c.x_offset_flipped = 8'h7f;
          c.clip_top = 9'd100;
          c.clip_bottom = 9'd300;
        end
        3: begin
          c.render_mode = 1'b1;
          c.cocktail_flip = 1'b1;
          c.sprite_color_mask = 8'hff;
          c.color_base = 8'($urandom);
        end
        4: begin
          c.x_offset_normal = 8'h7f;
          c.x_offset_flipped = 8'h80;
          c.clip_top = 9'd511;
          c.clip_bottom = 9'd0;
        end
        5: begin
          c.render_mode = 1'b1;
          c.sprite_color_mask = 8'h00;
          c.color_base = 8'hff;
          c.clip_top = 9'd2;
        end
        6: begin
          c.cocktail_flip = 1'b1;
          c.x_offset_normal = 8'($urandom);
          c.x_offset_flipped = 8'($urandom);
          c.clip_top = 9'd256;
        end
        7: begin
          c.render_mode = 1'b1;
          c.cocktail_flip = 1'($urandom);
          c.sprite_color_mask = 8'($urandom);
          c.color_base = 8'($urandom) & 8'hf0;
          c.clip_top = 9'($urandom_range(300));
          c.clip_bottom = 9'($urandom_range(c.clip_top, 511));
        end
        8: begin
          c.render_mode = 1'($urandom);
          c.cocktail_flip = 1'($urandom);
          c.x_offset_normal = 8'($urandom);
          c.x_offset_flipped = 8'($urandom);
          c.sprite_color_mask = 8'($urandom);
          c.color_base = 8'($urandom);
          c.clip_top = 9'($urandom_range(200));
          c.clip_bottom = 9'($urandom_range(300, 511));
        end
        default: ;
      endcase
      write_cfg(c);
      for (int j = 0; j < 4; j++) begin
        pool_y[j] = 8'($urandom);
        pool_x[j] = 8'($urandom);
      end
      quiet = (p == 0);
      if (p == 1 || p == 7) hold_off = 1'b1;
      n_items = (p == 4) ? 40 : 80;

      for (int i = 0; i < n_items; i++) begin
        if (p == 3 && i == 40) begin
          in_valid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
        r = $urandom_range(99);
        if (r < 30) begin
          if ($urandom_range(99) < 60) begin
            px = sb.aim_x;
            py = sb.aim_y;
          end else begin
            px = 9'($urandom);
            py = 9'($urandom);
          end
          r = $urandom_range(99);
          pval = (r < 25) ? PRI_MARK : (r < 40) ? PRI_CLEAR : 8'($urandom);
          send_item(REQ_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
                    5'($urandom), 8'($urandom), px, py, pval);
        end else begin
          // mostly a few sprites over a few pattern spots so entries get revisited
          if ($urandom_range(99) < 75) begin
            k = $urandom_range(3);
            ys = pool_y[k];
            xs = pool_x[k];
            row = 5'($urandom_range(3));
            col = 5'($urandom_range(3));
            if ($urandom_range(1)) row = ~row;
            if ($urandom_range(1)) col = ~col;
          end else begin
            ys = 8'($urandom);
            xs = 8'($urandom);
            row = 5'($urandom);
            col = 5'($urandom);
          end
          r = $urandom_range(99);
          ppix = (r < 10) ? PRI_CLEAR : (r < 40) ? 8'($urandom_range(15)) : 8'($urandom);
          send_pixel(ys, 8'($urandom), xs, row, col, ppix);
        end
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
